// ===== src/bracket_matrix_text_parser_top_macros.svh =====
// Assertion macros for the bracket matrix text parser checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BRACKET_MATRIX_TEXT_PARSER_TOP_MACROS_SVH
`define BRACKET_MATRIX_TEXT_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmtp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmtp assertion failed");

`endif

// ===== src/bmtp_pkg.sv =====
// Package for the bracket matrix text parser: character codes, error kinds
// and the result record passed from the parse core to the top level.
package bmtp_pkg;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_VTAB   = 8'h0B;
    localparam logic [7:0] CHAR_FF     = 8'h0C;

    localparam logic ERR_KIND_OPEN  = 1'b0;
    localparam logic ERR_KIND_CLOSE = 1'b1;

    localparam int POS_PORT_BITS = 32;

    typedef struct packed {
        logic                       has_result;
        logic                       number_valid;
        logic signed [63:0]         number_value;
        logic                       row_done;
        logic                       error_flag;
        logic                       error_kind;
        logic [POS_PORT_BITS-1:0]   line_number;
        logic [POS_PORT_BITS-1:0]   column_number;
    } t_result;

endpackage

// ===== src/bmtp_core.sv =====
// Parse core: holds the parser state and computes one item's result.
// Depends on bmtp_pkg for character codes and the result record.
module bmtp_core #(
    parameter int POSITION_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_text_byte,
    input  logic              i_end_of_input,
    output bmtp_pkg::t_result o_result
);
    import bmtp_pkg::*;

    logic                     r_bracket_open, n_bracket_open;
    logic                     r_row_open, n_row_open;
    logic                     r_row_nonempty, n_row_nonempty;
    logic [63:0]              r_accum, n_accum;
    logic                     r_digit_seen, n_digit_seen;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col, n_col;
    logic                     r_halted, n_halted;

    logic        flush;
    logic        emit;
    logic        done;
    logic        err;
    logic        kind;
    logic [3:0]  digit;

    // A pending value is emitted only into an open row.
    assign flush = r_digit_seen && r_row_open;
    assign digit = 4'(i_text_byte - CHAR_ZERO);

    always_comb begin
        n_bracket_open = r_bracket_open;
        n_row_open     = r_row_open;
        n_row_nonempty = r_row_nonempty;
        n_accum        = r_accum;
        n_digit_seen   = r_digit_seen;
        n_line         = r_line;
        n_col          = r_col + 1'b1;
        n_halted       = r_halted;
        emit           = 1'b0;
        done           = 1'b0;
        err            = 1'b0;
        kind           = ERR_KIND_OPEN;

        if (i_end_of_input) begin
            if (r_bracket_open) begin
                err  = 1'b1;
                kind = ERR_KIND_OPEN;
            end
        end else if (i_text_byte inside {[CHAR_ZERO:CHAR_NINE]}) begin
            n_accum      = (r_accum << 3) + (r_accum << 1) + 64'(digit);
            n_digit_seen = 1'b1;
        end else if (i_text_byte == CHAR_SEMI) begin
            emit           = flush;
            done           = r_row_open && (r_row_nonempty || flush);
            n_row_open     = 1'b1;
            n_row_nonempty = 1'b0;
        end else if (i_text_byte == CHAR_NL) begin
            n_line = r_line + 1'b1;
            n_col  = '0;
            emit   = flush;
            if (flush) begin
                n_row_nonempty = 1'b1;
            end
        end else if (i_text_byte inside {CHAR_SPACE, CHAR_CR, CHAR_TAB, CHAR_VTAB, CHAR_FF}) begin
            emit = flush;
            if (flush) begin
                n_row_nonempty = 1'b1;
            end
        end else if (i_text_byte == CHAR_LBRACK) begin
            if (r_bracket_open) begin
                err  = 1'b1;
                kind = ERR_KIND_OPEN;
            end else begin
                // Any open row is dropped; a pending value survives.
                n_bracket_open = 1'b1;
                n_row_open     = 1'b1;
                n_row_nonempty = 1'b0;
            end
        end else if (i_text_byte == CHAR_RBRACK) begin
            if (!r_bracket_open) begin
                err  = 1'b1;
                kind = ERR_KIND_CLOSE;
            end else begin
                n_bracket_open = 1'b0;
                emit           = flush;
                done           = r_row_open && (r_row_nonempty || flush);
                n_row_open     = 1'b0;
                n_row_nonempty = 1'b0;
            end
        end

        if (emit) begin
            n_accum      = '0;
            n_digit_seen = 1'b0;
        end
        if (err) begin
            n_halted = 1'b1;
        end
    end

    always_comb begin
        o_result.has_result    = !r_halted && (emit || done || err);
        o_result.number_valid  = emit;
        o_result.number_value  = emit ? r_accum : 64'd0;
        o_result.row_done      = done;
        o_result.error_flag    = err;
        o_result.error_kind    = err ? kind : ERR_KIND_OPEN;
        o_result.line_number   = POS_PORT_BITS'(n_line);
        o_result.column_number = POS_PORT_BITS'(n_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bracket_open <= 1'b0;
            r_row_open     <= 1'b0;
            r_row_nonempty <= 1'b0;
            r_accum        <= '0;
            r_digit_seen   <= 1'b0;
            r_line         <= '0;
            r_col          <= '0;
            r_halted       <= 1'b0;
        end else if (i_step && !r_halted) begin
            r_bracket_open <= n_bracket_open;
            r_row_open     <= n_row_open;
            r_row_nonempty <= n_row_nonempty;
            r_accum        <= n_accum;
            r_digit_seen   <= n_digit_seen;
            r_line         <= n_line;
            r_col          <= n_col;
            r_halted       <= n_halted;
        end
    end

endmodule

// ===== src/bracket_matrix_text_parser_top.sv =====
// Top level of the bracket matrix text parser: input register, parse core
// and result register. Depends on bmtp_pkg and bmtp_core.
//
//  channel | valid       | ready        | payload
//  --------+-------------+--------------+--------------------------------------
//  input   | i_in_valid  | o_in_ready   | i_text_byte, i_end_of_input
//  result  | o_out_valid | i_out_ready  | o_number_*, o_row_done, o_error_*,
//          |             |              | o_line_number, o_column_number
//
// One item per cycle sustained while the result side takes results; an item
// is held in the input register, and the core turns it into a result that is
// stored in the result register.
// Items that cause no result leave the result register untouched.
// Reset clears all parser state; after a bracket error the parser takes
// items but gives no results until reset. A stalled result holds the item
// in the input register, and the input side stalls once that is full too.
module bracket_matrix_text_parser_top #(
    parameter int POSITION_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_text_byte,
    input  logic               i_end_of_input,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_number_valid,
    output logic signed [63:0] o_number_value,
    output logic               o_row_done,
    output logic               o_error_flag,
    output logic               o_error_kind,
    output logic [31:0]        o_line_number,
    output logic [31:0]        o_column_number
);
    import bmtp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    bmtp_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_text_byte    (r_in_byte),
        .i_end_of_input (r_in_eoi),
        .o_result       (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_text_byte;
            r_in_eoi  <= i_end_of_input;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= core_result.has_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_result.has_result) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_number_valid  = r_out.number_valid;
    assign o_number_value  = r_out.number_value;
    assign o_row_done      = r_out.row_done;
    assign o_error_flag    = r_out.error_flag;
    assign o_error_kind    = r_out.error_kind;
    assign o_line_number   = r_out.line_number;
    assign o_column_number = r_out.column_number;

endmodule

// ===== src/bmtp_checker.sv =====
// Port-level checker for the bracket matrix text parser, bound to the top.
// Depends on bracket_matrix_text_parser_top_macros.svh for assertion macros.
`include "bracket_matrix_text_parser_top_macros.svh"

module bmtp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [7:0]         i_text_byte,
    input logic               i_end_of_input,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_number_valid,
    input logic signed [63:0] o_number_value,
    input logic               o_row_done,
    input logic               o_error_flag,
    input logic               o_error_kind,
    input logic [31:0]        o_line_number,
    input logic [31:0]        o_column_number
);

    // A stalled result keeps its valid and its value.
    `BMTP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_number_value) && $stable(o_column_number))

    // Every result carries a number, a finished row or an error.
    `BMTP_ASSERT_NOW(a_out_nonempty, i_clk, i_rst_n, o_out_valid, o_number_valid || o_row_done || o_error_flag)

    // The value field is zero unless a number is reported.
    `BMTP_ASSERT_NOW(a_value_zero, i_clk, i_rst_n, o_out_valid && !o_number_valid, o_number_value == 64'sd0)

    // An error stands alone, with no number and no row in the same result.
    `BMTP_ASSERT_NOW(a_err_alone, i_clk, i_rst_n, o_out_valid && o_error_flag, !o_number_valid && !o_row_done)

    // Once an error is taken the parser is halted and shows no more results.
    `BMTP_ASSERT_NEXT(a_halt_after_err, i_clk, i_rst_n, o_out_valid && o_error_flag && i_out_ready, !o_out_valid)

endmodule

bind bracket_matrix_text_parser_top bmtp_checker u_bmtp_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for bracket_matrix_text_parser_top: drives matrix text
// through the valid/ready channels and checks every number, row and error report.
// Depends on bmtp_pkg and the RTL of the parser top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bmtp_pkg::*;

    localparam int POS_BITS     = 32;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 60;
    localparam int TAIL_ITEMS   = 250;

    typedef struct {
        logic        number_valid;
        logic [63:0] number_value;
        logic        row_done;
        logic        error_flag;
        logic        error_kind;
        logic [31:0] line_number;
        logic [31:0] column_number;
    } t_parse_out;

    // Tracks the parser state and holds the reports that accepted text must produce.
    class matrix_text_tracker;
        bit                in_bracket;
        bit                in_row;
        bit                row_has_numbers;
        bit                have_digits;
        bit                stopped;
        bit [63:0]         pending_value;
        bit [POS_BITS-1:0] lines;
        bit [POS_BITS-1:0] columns;
        t_parse_out        waiting[$];
        int                mismatches;

        function void flush_number(output bit emitted, output bit [63:0] value);
            emitted = have_digits && in_row;
            value = emitted ? pending_value : 64'd0;
            if (emitted) begin
                pending_value = 64'd0;
                have_digits = 1'b0;
                row_has_numbers = 1'b1;
            end
        endfunction

        function void take_char(logic [7:0] ch, logic eoi);
            t_parse_out r;
            bit         emit;
            bit         done;
            bit         err;
            bit         kind;
            bit [63:0]  value;
            emit = 1'b0;
            done = 1'b0;
            err = 1'b0;
            kind = ERR_KIND_OPEN;
            value = 64'd0;
            if (stopped)
                return;
            columns++;
            if (eoi) begin
                err = in_bracket;
            end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                pending_value = pending_value * 64'd10 + 64'(ch - CHAR_ZERO);
                have_digits = 1'b1;
            end else if (ch == CHAR_SEMI) begin
                flush_number(emit, value);
                done = in_row && row_has_numbers;
                in_row = 1'b1;
                row_has_numbers = 1'b0;
            end else if (ch == CHAR_NL) begin
                lines++;
                columns = '0;
                flush_number(emit, value);
            end else if (ch == CHAR_SPACE || ch == CHAR_CR || ch == CHAR_TAB ||
                         ch == CHAR_VTAB || ch == CHAR_FF) begin
                flush_number(emit, value);
            end else if (ch == CHAR_LBRACK) begin
                if (in_bracket) begin
                    err = 1'b1;
                end else begin
                    // Any open row is dropped silently; a pending value survives.
                    in_bracket = 1'b1;
                    in_row = 1'b1;
                    row_has_numbers = 1'b0;
                end
            end else if (ch == CHAR_RBRACK) begin
                if (!in_bracket) begin
                    err = 1'b1;
                    kind = ERR_KIND_CLOSE;
                end else begin
                    in_bracket = 1'b0;
                    flush_number(emit, value);
                    done = in_row && row_has_numbers;
                    in_row = 1'b0;
                    row_has_numbers = 1'b0;
                end
            end
            if (err)
                stopped = 1'b1;
            if (emit || done || err) begin
                r.number_valid = emit;
                r.number_value = value;
                r.row_done = done;
                r.error_flag = err;
                r.error_kind = err ? kind : ERR_KIND_OPEN;
                r.line_number = 32'(lines);
                r.column_number = 32'(columns);
                waiting.push_back(r);
            end
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_output(t_parse_out got);
            t_parse_out want;
            if (waiting.size() == 0) begin
                $error("result arrived with no item waiting for it");
                mismatches++;
                return;
            end
            want = waiting.pop_front();
            check_field("number_valid", want.number_valid, got.number_valid);
            check_field("number_value", want.number_value, got.number_value);
            check_field("row_done", want.row_done, got.row_done);
            check_field("error_flag", want.error_flag, got.error_flag);
            check_field("error_kind", want.error_kind, got.error_kind);
            check_field("line_number", want.line_number, got.line_number);
            check_field("column_number", want.column_number, got.column_number);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_text_byte;
    logic               i_end_of_input;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_number_valid;
    logic signed [63:0] o_number_value;
    logic               o_row_done;
    logic               o_error_flag;
    logic               o_error_kind;
    logic [31:0]        o_line_number;
    logic [31:0]        o_column_number;

    matrix_text_tracker tracker = new;
    bit quiet_tail;
    bit sender_calm;
    int items_sent;
    int noise_sent;

    bracket_matrix_text_parser_top #(
        .POSITION_BITS(POS_BITS)
    ) u_top (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic drive_item(logic [7:0] ch, logic eoi);
        if (!quiet_tail && !sender_calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_text_byte <= ch;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_char(ch, eoi);
        items_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            drive_item(s[i], 1'b0);
    endtask

    task automatic send_number();
        int pick;
        int digits;
        pick = $urandom_range(0, 24);
        if (pick == 0) begin
            send_text("18446744073709551615");
        end else if (pick == 1) begin
            send_text("9223372036854775808");
        end else if (pick == 2) begin
            send_text("99999999999999999999999");
        end else begin
            digits = (pick == 3) ? $urandom_range(19, 24) : $urandom_range(1, 4);
            repeat (digits)
                drive_item(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
    endtask

    task automatic send_gap(bit needed);
        int         count;
        logic [7:0] c;
        count = needed ? $urandom_range(1, 2) : $urandom_range(0, 2);
        repeat (count) begin
            case ($urandom_range(0, 9))
                0: c = CHAR_TAB;
                1: c = CHAR_CR;
                2: c = CHAR_VTAB;
                3: c = CHAR_FF;
                4: c = CHAR_NL;
                default: c = CHAR_SPACE;
            endcase
            drive_item(c, 1'b0);
        end
    endtask

    // Mostly bracketed matrices; the rest are rows opened by a semicolon alone.
    task automatic send_matrix();
        int rows;
        int cols;
        bit bracketed;
        bracketed = $urandom_range(0, 4) != 0;
        if (bracketed) begin
            if (tracker.in_bracket)
                drive_item(CHAR_RBRACK, 1'b0);
            drive_item(CHAR_LBRACK, 1'b0);
        end else begin
            drive_item(CHAR_SEMI, 1'b0);
        end
        rows = $urandom_range(1, 4);
        for (int r = 0; r < rows; r++) begin
            if (r > 0) begin
                send_gap(1'b0);
                drive_item(CHAR_SEMI, 1'b0);
            end
            cols = $urandom_range(0, 5);
            for (int c = 0; c < cols; c++) begin
                send_gap(c > 0);
                send_number();
            end
        end
        send_gap(1'b0);
        drive_item(bracketed ? CHAR_RBRACK : CHAR_SEMI, 1'b0);
        send_gap(1'b0);
        if (!tracker.in_bracket && $urandom_range(0, 7) == 0)
            drive_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Random bytes, kept clear of bracket errors so the parser stays alive.
    task automatic send_noise();
        logic [7:0] c;
        repeat ($urandom_range(1, 4)) begin
            c = 8'($urandom_range(0, 255));
            if ((c == CHAR_LBRACK && tracker.in_bracket) ||
                (c == CHAR_RBRACK && !tracker.in_bracket))
                c = c ^ 8'h01;
            drive_item(c, !tracker.in_bracket && $urandom_range(0, 9) == 0);
            noise_sent++;
        end
    endtask

    // Only one bracket error can be seen per run, since it halts the parser for good.
    task automatic trigger_error();
        case ($urandom_range(0, 2))
            0: begin
                if (!tracker.in_bracket)
                    drive_item(CHAR_LBRACK, 1'b0);
                drive_item(CHAR_LBRACK, 1'b0);
            end
            1: begin
                if (tracker.in_bracket)
                    drive_item(CHAR_RBRACK, 1'b0);
                drive_item(CHAR_RBRACK, 1'b0);
            end
            default: begin
                if (!tracker.in_bracket)
                    drive_item(CHAR_LBRACK, 1'b0);
                drive_item(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        repeat (8)
            drive_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int  target;
        bit  drained;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_text_byte <= 8'h00;
        i_end_of_input <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pre-row digits survive separators and are emitted by the first separator in a row.
        send_text("12 ");
        drive_item(CHAR_SEMI, 1'b0);
        send_text("4 ");
        // A bracket over the open row drops that row without a report.
        drive_item(CHAR_LBRACK, 1'b0);
        send_text("5");
        drive_item(CHAR_TAB, 1'b0);
        send_text("6");
        drive_item(CHAR_CR, 1'b0);
        send_text("7");
        drive_item(CHAR_VTAB, 1'b0);
        send_text("8");
        drive_item(CHAR_FF, 1'b0);
        send_text("9");
        drive_item(CHAR_SEMI, 1'b0);
        drive_item(CHAR_SEMI, 1'b0);
        drive_item(CHAR_NL, 1'b0);
        drive_item(CHAR_RBRACK, 1'b0);
        drive_item(8'h00, 1'b0);
        drive_item(8'hFF, 1'b0);
        send_text("x");
        drive_item(8'h00, 1'b1);
        drive_item(CHAR_LBRACK, 1'b0);
        send_text("3");
        drive_item(CHAR_RBRACK, 1'b0);
        drive_item(CHAR_NL, 1'b0);

        target = items_sent + RANDOM_ITEMS;
        drained = 1'b0;
        while (items_sent - noise_sent < target) begin
            if (!drained && items_sent - noise_sent >= target - RANDOM_ITEMS / 2) begin
                drained = 1'b1;
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (tracker.waiting.size() != 0);
            end
            quiet_tail = items_sent - noise_sent >= target - TAIL_ITEMS;
            sender_calm = $urandom_range(0, 4) == 0;
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_matrix();
        end
        trigger_error();

        i_in_valid <= 1'b0;
        while (tracker.waiting.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.waiting.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off that backs up the input side.
    initial begin
        int         idle_left;
        int         hold_left;
        int         results_seen;
        int         since_pick;
        bit         hold_done;
        bit         calm;
        t_parse_out got;
        idle_left = 0;
        hold_left = 0;
        results_seen = 0;
        since_pick = 0;
        hold_done = 1'b0;
        calm = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.number_valid = o_number_valid;
                got.number_value = o_number_value;
                got.row_done = o_row_done;
                got.error_flag = o_error_flag;
                got.error_kind = o_error_kind;
                got.line_number = o_line_number;
                got.column_number = o_column_number;
                tracker.compare_output(got);
                results_seen++;
            end
            if (++since_pick == 64) begin
                since_pick = 0;
                calm = $urandom_range(0, 3) == 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 150) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                i_out_ready <= 1'b0;
            end else if (!quiet_tail && !calm && $urandom_range(0, 4) == 0) begin
                idle_left = $urandom_range(0, 4);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
